// ===== hdl/lpd_pkg.sv =====
package lpd_pkg;

   // header layout: 32-bit little-endian length, then 32-bit little-endian id
   localparam int HEADER_BYTES = 8;
   localparam int HDR_COUNT_W  = $clog2(HEADER_BYTES);
   localparam logic [HDR_COUNT_W-1:0] HDR_LAST = HDR_COUNT_W'(HEADER_BYTES - 1);

   localparam int BYTE_W = 8;
   localparam int WORD_W = 32;

   localparam logic [WORD_W-1:0] MAX_LEN_RESET = 32'd65535;

   // one result item
   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic [WORD_W-1:0] message_id;
      logic [WORD_W-1:0] message_length;
      logic              is_last;
      logic              is_empty;
      logic              length_error;
   } rsp_type;

   // replace one byte lane of a little-endian word
   function automatic logic [WORD_W-1:0] set_lane(input logic [WORD_W-1:0] word,
                                                  input logic [1:0]        lane,
                                                  input logic [BYTE_W-1:0] data);
      logic [WORD_W-1:0] res;
      res = word;
      case (lane)
         2'd0:    res[7:0]   = data;
         2'd1:    res[15:8]  = data;
         2'd2:    res[23:16] = data;
         2'd3:    res[31:24] = data;
         default: res = word;
      endcase
      return res;
   endfunction

endpackage

// ===== hdl/lpd_parser.sv =====
module lpd_parser
   import lpd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic [WORD_W-1:0] max_len,
   output logic              res_valid,
   output rsp_type           res
);

   logic [HDR_COUNT_W-1:0] header_count_ff, header_count_in;
   logic                   in_payload_ff, in_payload_in;
   logic [WORD_W-1:0]      length_reg_ff, length_reg_in;
   logic [WORD_W-1:0]      id_reg_ff, id_reg_in;
   logic [WORD_W-1:0]      remaining_ff, remaining_in;
   logic [WORD_W-1:0]      rem_dec;

   // next state and result for the byte in the input register
   always_comb begin
      header_count_in = header_count_ff;
      in_payload_in   = in_payload_ff;
      length_reg_in   = length_reg_ff;
      id_reg_in       = id_reg_ff;
      remaining_in    = remaining_ff;
      rem_dec         = remaining_ff - WORD_W'(1);

      res_valid          = 1'b0;
      res.payload_byte   = '0;
      res.message_id     = id_reg_ff;
      res.message_length = length_reg_ff;
      res.is_last        = 1'b0;
      res.is_empty       = 1'b0;
      res.length_error   = 1'b0;

      if (in_payload_ff) begin
         // payload byte: count down, mark the final one
         remaining_in     = rem_dec;
         res_valid        = 1'b1;
         res.payload_byte = data_byte;
         res.is_last      = (rem_dec == '0);
         if (rem_dec == '0) begin
            in_payload_in   = 1'b0;
            header_count_in = '0;
         end
      end else begin
         // header byte: length lanes first, id lanes after
         if (!header_count_ff[2]) begin
            length_reg_in = set_lane(length_reg_ff, header_count_ff[1:0], data_byte);
         end else begin
            id_reg_in = set_lane(id_reg_ff, header_count_ff[1:0], data_byte);
         end
         res.message_id = id_reg_in;

         if (header_count_ff != HDR_LAST) begin
            header_count_in = header_count_ff + HDR_COUNT_W'(1);
         end else begin
            header_count_in = '0;
            if (length_reg_ff > max_len) begin
               res_valid        = 1'b1;
               res.is_last      = 1'b1;
               res.length_error = 1'b1;
            end else if (length_reg_ff == '0) begin
               res_valid    = 1'b1;
               res.is_last  = 1'b1;
               res.is_empty = 1'b1;
            end else begin
               in_payload_in = 1'b1;
               remaining_in  = length_reg_ff;
            end
         end
      end
   end

   // deframer state
   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff <= '0;
         in_payload_ff   <= 1'b0;
         length_reg_ff   <= '0;
         id_reg_ff       <= '0;
         remaining_ff    <= '0;
      end else if (step) begin
         header_count_ff <= header_count_in;
         in_payload_ff   <= in_payload_in;
         length_reg_ff   <= length_reg_in;
         id_reg_ff       <= id_reg_in;
         remaining_ff    <= remaining_in;
      end
   end

   // no header bytes are counted while payload is running
   assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (header_count_ff == '0))
      else $error("header count nonzero during payload");

   // an error or empty result always closes the message
   assert property (@(posedge clock) disable iff (reset)
      (res_valid && (res.length_error || res.is_empty)) |-> (res.is_last && !in_payload_ff))
      else $error("error or empty result not final");

   // error and empty never flag together
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !(res.length_error && res.is_empty))
      else $error("error and empty both set");

   // a payload in flight always has bytes left
   assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (remaining_ff != '0))
      else $error("payload active with zero remaining");

endmodule

// ===== hdl/lpd_out_reg.sv =====
module lpd_out_reg
   import lpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type res,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   output logic    can_load
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // slot is free when empty or being taken this cycle
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) begin
         valid_in = load;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load && load) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== hdl/length_prefixed_deframer_core.sv =====
// channel   direction  handshake                  payload
// request   in         req_valid / req_ready      req_data_byte
// response  out        rsp_valid / rsp_ready      rsp_payload_byte .. rsp_length_error
// csr       in         csr_write_enable           csr_write_data (max payload length)
//
// one byte per cycle while the response side is not stalled: input register, one pass of deframe logic, result register
// an accepted request moves from the input register into the result register once the result slot can take it
// header bytes produce no response; each payload byte, empty or error produces one
// reset is synchronous, active high; max payload length returns to 65535
// a stalled response holds the result register and then the input register
module length_prefixed_deframer_core
   import lpd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_payload_byte,
   output logic [WORD_W-1:0] rsp_message_id,
   output logic [WORD_W-1:0] rsp_message_length,
   output logic              rsp_is_last,
   output logic              rsp_is_empty,
   output logic              rsp_length_error,
   input  logic              csr_write_enable,
   input  logic [WORD_W-1:0] csr_write_data
);

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic [WORD_W-1:0] max_len_ff;
   logic              advance;
   logic              can_load;
   logic              res_valid;
   rsp_type           res;
   rsp_type           rsp_data;

   // byte leaves the input register when the result slot can take it
   assign advance   = in_valid_ff && can_load;
   assign req_ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
      end
   end

   // max payload length register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_write_enable) begin
         max_len_ff <= csr_write_data;
      end
   end

   lpd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .max_len   (max_len_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   lpd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && res_valid),
      .res       (res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .can_load  (can_load)
   );

   assign rsp_payload_byte   = rsp_data.payload_byte;
   assign rsp_message_id     = rsp_data.message_id;
   assign rsp_message_length = rsp_data.message_length;
   assign rsp_is_last        = rsp_data.is_last;
   assign rsp_is_empty       = rsp_data.is_empty;
   assign rsp_length_error   = rsp_data.length_error;

endmodule

// ===== verif/length_prefixed_deframer_checker.sv =====
module length_prefixed_deframer_checker
   import lpd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [BYTE_W-1:0] rsp_payload_byte,
   input  logic [WORD_W-1:0] rsp_message_id,
   input  logic [WORD_W-1:0] rsp_message_length,
   input  logic              rsp_is_last,
   input  logic              rsp_is_empty,
   input  logic              rsp_length_error,
   input  logic              csr_write_enable,
   input  logic [WORD_W-1:0] csr_write_data,
   output int                error_count,
   output int                undelivered_count,
   output int                checked_count
);

   localparam int MAX_REPORTS = 10;

   // shadow of the deframer state
   logic [HDR_COUNT_W-1:0] hdr_cnt;
   logic                   in_body;
   logic [WORD_W-1:0]      len_word;
   logic [WORD_W-1:0]      id_word;
   logic [WORD_W-1:0]      bytes_left;
   logic [WORD_W-1:0]      max_len;

   // responses predicted but not yet delivered, oldest first
   rsp_type deframed_q[$];

   initial begin
      error_count       = 0;
      undelivered_count = 0;
      checked_count     = 0;
   end

   // advance the shadow state by one stream byte, queue any response it causes
   task automatic deframe_byte(input logic [BYTE_W-1:0] b);
      rsp_type r;
      r = '0;
      if (in_body) begin
         bytes_left       = bytes_left - 1;
         r.payload_byte   = b;
         r.message_id     = id_word;
         r.message_length = len_word;
         r.is_last        = (bytes_left == 0);
         deframed_q.push_back(r);
         if (bytes_left == 0) begin
            in_body = 1'b0;
            hdr_cnt = '0;
         end
      end else begin
         // little-endian length in bytes 0..3, id in bytes 4..7
         if (hdr_cnt < 4)
            len_word[8*hdr_cnt +: 8] = b;
         else
            id_word[8*(hdr_cnt-4) +: 8] = b;
         if (hdr_cnt != HDR_LAST) begin
            hdr_cnt = hdr_cnt + 1'b1;
         end else begin
            hdr_cnt          = '0;
            r.message_id     = id_word;
            r.message_length = len_word;
            r.is_last        = 1'b1;
            // length checked against the limit in force right now
            if (len_word > max_len) begin
               r.length_error = 1'b1;
               deframed_q.push_back(r);
            end else if (len_word == 0) begin
               r.is_empty = 1'b1;
               deframed_q.push_back(r);
            end else begin
               in_body    = 1'b1;
               bytes_left = len_word;
            end
         end
      end
   endtask

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch (%s) at %0t: expected byte=%h id=%h len=%h last=%b empty=%b err=%b",
                  what, $time, want.payload_byte, want.message_id, want.message_length,
                  want.is_last, want.is_empty, want.length_error,
                  " / actual byte=%h id=%h len=%h last=%b empty=%b err=%b",
                  got.payload_byte, got.message_id, got.message_length,
                  got.is_last, got.is_empty, got.length_error);
   endtask

   // compare delivered responses, then track csr writes and accepted requests
   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         hdr_cnt    = '0;
         in_body    = 1'b0;
         len_word   = '0;
         id_word    = '0;
         bytes_left = '0;
         max_len    = MAX_LEN_RESET;
         deframed_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.payload_byte   = rsp_payload_byte;
            got.message_id     = rsp_message_id;
            got.message_length = rsp_message_length;
            got.is_last        = rsp_is_last;
            got.is_empty       = rsp_is_empty;
            got.length_error   = rsp_length_error;
            checked_count++;
            if (deframed_q.size() == 0) begin
               note_mismatch("unexpected response", '0, got);
            end else begin
               want = deframed_q.pop_front();
               if (got.payload_byte !== want.payload_byte ||
                   got.message_id !== want.message_id ||
                   got.message_length !== want.message_length ||
                   got.is_last !== want.is_last ||
                   got.is_empty !== want.is_empty ||
                   got.length_error !== want.length_error)
                  note_mismatch("field", want, got);
            end
         end
         if (csr_write_enable)
            max_len = csr_write_data;
         if (req_valid && req_ready)
            deframe_byte(req_data_byte);
      end
      undelivered_count = deframed_q.size();
   end

endmodule

// ===== verif/length_prefixed_deframer_core_tb.sv =====
module length_prefixed_deframer_core_tb
   import lpd_pkg::*;
;

   localparam int SETTLE_CYCLES  = 4;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_BYTES    = 55;
   localparam int NUM_PHASES     = 6;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [BYTE_W-1:0] req_data_byte;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [BYTE_W-1:0] rsp_payload_byte;
   logic [WORD_W-1:0] rsp_message_id;
   logic [WORD_W-1:0] rsp_message_length;
   logic              rsp_is_last;
   logic              rsp_is_empty;
   logic              rsp_length_error;
   logic              csr_write_enable;
   logic [WORD_W-1:0] csr_write_data;

   int error_count;
   int undelivered_count;
   int checked_count;

   // stimulus bookkeeping
   logic [WORD_W-1:0] cur_max;
   int                bytes_sent;
   int                frames_sent;
   int                empty_frames;
   int                oversized_frames;
   int                csr_writes;
   int                burst_left;
   bit                no_gaps;
   bit                hold_start;
   int                quiet_cycles;

   length_prefixed_deframer_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_message_id     (rsp_message_id),
      .rsp_message_length (rsp_message_length),
      .rsp_is_last        (rsp_is_last),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_length_error   (rsp_length_error),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   length_prefixed_deframer_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_message_id     (rsp_message_id),
      .rsp_message_length (rsp_message_length),
      .rsp_is_last        (rsp_is_last),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_length_error   (rsp_length_error),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .error_count        (error_count),
      .undelivered_count  (undelivered_count),
      .checked_count      (checked_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog on cycles with no handshake on either channel
   initial quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // response side: random ready pattern, plus long hold-offs on request
   initial begin : receiver
      int hold_left;
      int ready_pct;
      int pattern_age;
      hold_left   = 0;
      ready_pct   = 100;
      pattern_age = 0;
      rsp_ready   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (pattern_age == 0) begin
               pattern_age = $urandom_range(20, 80);
               case ($urandom_range(0, 4))
                  0, 1:    ready_pct = 100;
                  2:       ready_pct = 75;
                  3:       ready_pct = 45;
                  default: ready_pct = 15;
               endcase
            end
            pattern_age--;
            rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   // one stream byte, in bursts separated by random gaps
   task automatic push_byte(input logic [BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = no_gaps ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   // stop offering and wait until every predicted response has been delivered
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (undelivered_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_max(input logic [WORD_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cur_max = value;
      csr_writes++;
   endtask

   function automatic logic [BYTE_W-1:0] header_byte(input logic [WORD_W-1:0] len,
                                                     input logic [WORD_W-1:0] id,
                                                     input int k);
      if (k < 4)
         return len[8*k +: 8];
      return id[8*(k-4) +: 8];
   endfunction

   // payload follows only when the header length is nonzero and within the length limit
   task automatic finish_frame(input logic [WORD_W-1:0] len);
      frames_sent++;
      if (len > cur_max) begin
         oversized_frames++;
      end else if (len == 0) begin
         empty_frames++;
      end else begin
         for (logic [WORD_W-1:0] i = 0; i < len; i++)
            push_byte(BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_frame(input logic [WORD_W-1:0] len, input logic [WORD_W-1:0] id);
      for (int k = 0; k < HEADER_BYTES; k++)
         push_byte(header_byte(len, id, k));
      finish_frame(len);
   endtask

   // mostly legal frames, some empty, some over the limit, some random headers
   function automatic logic [WORD_W-1:0] pick_length();
      int unsigned       roll;
      logic [WORD_W-1:0] cap;
      logic [WORD_W-1:0] v;
      roll = $urandom_range(0, 99);
      cap  = (cur_max < 24) ? cur_max : 24;
      if (roll < 10)
         return 0;
      if (roll < 75 || cur_max == '1)
         return $urandom_range(cap, 0);
      if (roll < 83)
         return cur_max + 1;
      if (roll < 90)
         return cur_max + 1 + ($urandom() % ('1 - cur_max));
      v = $urandom();
      if (v <= cur_max)
         v = v % (cap + 1);
      return v;
   endfunction

   // stimulus
   initial begin : stimulus
      logic [WORD_W-1:0] next_max;
      int                phase_end;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      hold_start       = 1'b0;
      no_gaps          = 1'b0;
      burst_left       = 0;
      bytes_sent       = 0;
      frames_sent      = 0;
      empty_frames     = 0;
      oversized_frames = 0;
      csr_writes       = 0;
      cur_max          = MAX_LEN_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty frame, limit from reset, single byte, limit changed mid-header, limit 0
      send_frame(32'd0, 32'hFFFF_FFFF);
      send_frame(32'h0001_0000, 32'd0);
      send_frame(32'd1, 32'h8000_0001);
      for (int k = 0; k < HEADER_BYTES - 1; k++)
         push_byte(header_byte(32'd6, 32'h5A5A_A5A5, k));
      drain();
      write_max(32'd5);
      push_byte(header_byte(32'd6, 32'h5A5A_A5A5, HEADER_BYTES - 1));
      finish_frame(32'd6);
      drain();
      write_max(32'd0);
      send_frame(32'hFFFF_FFFF, 32'h0F0F_F0F0);
      send_frame(32'd0, 32'hC3C3_3C3C);

      // random phases, each under its own length limit
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       next_max = MAX_LEN_RESET;
            1:       next_max = 32'd0;
            2:       next_max = 32'hFFFF_FFFF;
            3:       next_max = 32'd1;
            4:       next_max = $urandom_range(30, 5);
            default: next_max = $urandom();
         endcase
         drain();
         write_max(next_max);
         no_gaps = (p == 3);
         if (p == 2) begin
            // hold responses back while a long frame keeps coming
            hold_start = 1'b1;
            no_gaps    = 1'b1;
            send_frame(32'd60, $urandom());
            no_gaps    = 1'b0;
         end
         phase_end = bytes_sent + PHASE_BYTES;
         while (bytes_sent < phase_end)
            send_frame(pick_length(), $urandom());
      end

      drain();
      $display("covered %0d bytes in %0d frames (%0d empty, %0d over the limit), %0d csr writes",
               bytes_sent, frames_sent, empty_frames, oversized_frames, csr_writes);
      $display("checked %0d responses under limits from 0 to all-ones", checked_count);
      if (error_count == 0 && undelivered_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
